### src/associative_page_table_assert.svh
// Assertion macros used by the checker of the associative page table.
// Depends on nothing; included by the checker file.
`ifndef ASSOCIATIVE_PAGE_TABLE_ASSERT_SVH
`define ASSOCIATIVE_PAGE_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define APT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define APT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### src/apt_pkg.sv
// Shared types and constants of the associative page table.
// Depends on nothing; used by every module of the block except apt_ram.
package apt_pkg;

   localparam int NUM_ENTRIES_DEF = 16;
   localparam int PAGE_BITS_DEF   = 20;
   localparam int FRAME_BITS_DEF  = 16;
   localparam int FUNC_W          = 3;

   localparam logic [FUNC_W-1:0] FUNC_ADD         = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE      = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP      = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SET_VALID   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR_VALID = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_SET_DIRTY   = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR_DIRTY = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_COMPARE = 4'b0010,
      ST_COMMIT  = 4'b0100,
      ST_RESPOND = 4'b1000
   } apt_state_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic commit;
   } apt_cmd_type;

endpackage

### src/apt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module apt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/apt_ctrl.sv
// Controller of the associative page table: walks one operation through
// compare, commit and respond. Depends on apt_pkg.
module apt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output apt_pkg::apt_cmd_type cmd
);

   apt_pkg::apt_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         apt_pkg::ST_IDLE: begin
            if (start) begin
               state_in = apt_pkg::ST_COMPARE;
            end
         end
         apt_pkg::ST_COMPARE: state_in = apt_pkg::ST_COMMIT;
         apt_pkg::ST_COMMIT:  state_in = apt_pkg::ST_RESPOND;
         apt_pkg::ST_RESPOND: state_in = apt_pkg::ST_IDLE;
         default:             state_in = apt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= apt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff != apt_pkg::ST_IDLE);
   assign rsp_valid   = (state_ff == apt_pkg::ST_RESPOND);
   assign cmd.load    = (state_ff == apt_pkg::ST_IDLE) && start;
   assign cmd.compare = (state_ff == apt_pkg::ST_COMPARE);
   assign cmd.commit  = (state_ff == apt_pkg::ST_COMMIT);

endmodule

### src/apt_datapath.sv
// Datapath of the associative page table: tag store, occupancy and marks,
// parallel tag compare, slot pick and the frame RAM. Depends on apt_pkg, apt_ram.
module apt_datapath #(
   parameter int NUM_ENTRIES = apt_pkg::NUM_ENTRIES_DEF,
   parameter int PAGE_BITS   = apt_pkg::PAGE_BITS_DEF,
   parameter int FRAME_BITS  = apt_pkg::FRAME_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  apt_pkg::apt_cmd_type      cmd,
   input  logic [apt_pkg::FUNC_W-1:0] req_func,
   input  logic [PAGE_BITS-1:0]      req_page,
   input  logic [FRAME_BITS-1:0]     req_frame_in,
   output logic                      rsp_ok,
   output logic [FRAME_BITS-1:0]     rsp_frame_out,
   output logic                      rsp_page_valid,
   output logic                      rsp_page_dirty
);

   localparam int IDX_W = $clog2(NUM_ENTRIES);

   // Captured request.
   logic [apt_pkg::FUNC_W-1:0] func_ff;
   logic [PAGE_BITS-1:0]       page_ff;
   logic [FRAME_BITS-1:0]      frame_ff;

   // Table state.
   logic [PAGE_BITS-1:0]   tag_ff [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] used_ff;
   logic [NUM_ENTRIES-1:0] valid_ff;
   logic [NUM_ENTRIES-1:0] dirty_ff;

   // Compare results.
   logic [NUM_ENTRIES-1:0] match_ff, match_in;
   logic [NUM_ENTRIES-1:0] free_ff;

   // Response registers.
   logic ok_ff, ok_in;
   logic pv_ff, pv_in;
   logic pd_ff, pd_in;
   logic hit_lookup_ff, hit_lookup_in;

   logic [NUM_ENTRIES-1:0] sel_vec;
   logic [IDX_W-1:0]       idx;
   logic                   any_sel;
   logic                   is_add;
   logic                   legal_op;
   logic                   new_valid;
   logic                   new_dirty;
   logic [FRAME_BITS-1:0]  ram_rd_data;

   always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         match_in[i] = used_ff[i] && (tag_ff[i] == page_ff);
      end
   end

   assign is_add   = (func_ff == apt_pkg::FUNC_ADD);
   assign legal_op = (func_ff <= apt_pkg::FUNC_CLEAR_DIRTY);
   assign sel_vec  = is_add ? free_ff : match_ff;
   assign any_sel  = |sel_vec;

   // Lowest set bit of the selected vector.
   always_comb begin
      idx = '0;
      for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
         if (sel_vec[i]) begin
            idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      new_valid = valid_ff[idx];
      new_dirty = dirty_ff[idx];
      case (func_ff)
         apt_pkg::FUNC_REMOVE: begin
            new_valid = 1'b0;
            new_dirty = 1'b0;
         end
         apt_pkg::FUNC_SET_VALID:   new_valid = 1'b1;
         apt_pkg::FUNC_CLEAR_VALID: new_valid = 1'b0;
         apt_pkg::FUNC_SET_DIRTY:   new_dirty = 1'b1;
         apt_pkg::FUNC_CLEAR_DIRTY: new_dirty = 1'b0;
         default: ;
      endcase
   end

   always_comb begin
      ok_in         = legal_op && any_sel;
      pv_in         = ok_in && !is_add && new_valid;
      pd_in         = ok_in && !is_add && new_dirty;
      hit_lookup_in = any_sel && (func_ff == apt_pkg::FUNC_LOOKUP);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         page_ff  <= req_page;
         frame_ff <= req_frame_in;
      end
      if (cmd.compare) begin
         match_ff <= match_in;
         free_ff  <= ~used_ff;
      end
      if (cmd.commit) begin
         ok_ff         <= ok_in;
         pv_ff         <= pv_in;
         pd_ff         <= pd_in;
         hit_lookup_ff <= hit_lookup_in;
         if (is_add && any_sel) begin
            tag_ff[idx] <= page_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         valid_ff <= '0;
         dirty_ff <= '0;
      end else if (cmd.commit && ok_in) begin
         if (is_add) begin
            used_ff[idx]  <= 1'b1;
            valid_ff[idx] <= 1'b0;
            dirty_ff[idx] <= 1'b0;
         end else begin
            if (func_ff == apt_pkg::FUNC_REMOVE) begin
               used_ff[idx] <= 1'b0;
            end
            valid_ff[idx] <= new_valid;
            dirty_ff[idx] <= new_dirty;
         end
      end
   end

   apt_ram #(
      .WIDTH (FRAME_BITS),
      .DEPTH (NUM_ENTRIES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && is_add && any_sel),
      .wr_addr (idx),
      .wr_data (frame_ff),
      .rd_en   (cmd.commit),
      .rd_addr (idx),
      .rd_data (ram_rd_data)
   );

   assign rsp_ok         = ok_ff;
   assign rsp_page_valid = pv_ff;
   assign rsp_page_dirty = pd_ff;
   assign rsp_frame_out  = hit_lookup_ff ? ram_rd_data : '0;

endmodule

### src/associative_page_table.sv
// Top level of the associative page table; depends on apt_pkg, apt_ctrl,
// apt_datapath and, through the datapath, apt_ram.
//
// Usage: an operation (req_func, req_page, req_frame_in) is transferred at a
// rising edge where start is high and busy is low. Operations are add, remove,
// lookup, and set or clear of the valid and dirty marks, matched by page
// against every occupied slot at once; the lowest matching slot wins, and an
// add takes the lowest free slot without a duplicate check.
// Each operation yields exactly one result, shown on the rsp_ ports for one
// cycle with rsp_valid high. The steps in order: the registered tag compare;
// the slot pick, the update of the table and frame RAM and the start of the
// registered frame RAM read; and the showing of the registered result. busy
// stays high over those steps, so a new operation is not taken before the
// last result has been shown; the controller handles one operation at a time.
// The receiver cannot stall: a result is transferred in its strobe cycle.
// Synchronous reset empties the table and clears all marks at once; the tag
// and frame stores are not cleared and need no sweep.
module associative_page_table #(
   parameter int NUM_ENTRIES = apt_pkg::NUM_ENTRIES_DEF,
   parameter int PAGE_BITS   = apt_pkg::PAGE_BITS_DEF,
   parameter int FRAME_BITS  = apt_pkg::FRAME_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [apt_pkg::FUNC_W-1:0] req_func,
   input  logic [PAGE_BITS-1:0]       req_page,
   input  logic [FRAME_BITS-1:0]      req_frame_in,
   output logic                       rsp_valid,
   output logic                       rsp_ok,
   output logic [FRAME_BITS-1:0]      rsp_frame_out,
   output logic                       rsp_page_valid,
   output logic                       rsp_page_dirty
);

   // Command group from the controller to the datapath.
   apt_pkg::apt_cmd_type cmd;

   apt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // The datapath holds all table state and the frame RAM.
   apt_datapath #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .PAGE_BITS   (PAGE_BITS),
      .FRAME_BITS  (FRAME_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_func       (req_func),
      .req_page       (req_page),
      .req_frame_in   (req_frame_in),
      .rsp_ok         (rsp_ok),
      .rsp_frame_out  (rsp_frame_out),
      .rsp_page_valid (rsp_page_valid),
      .rsp_page_dirty (rsp_page_dirty)
   );

endmodule

### src/apt_checker.sv
// Port-level checker of the associative page table, bound to the top level.
// Depends on apt_pkg and associative_page_table_assert.svh.
`include "associative_page_table_assert.svh"

module apt_checker #(
   parameter int PAGE_BITS  = apt_pkg::PAGE_BITS_DEF,
   parameter int FRAME_BITS = apt_pkg::FRAME_BITS_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic [apt_pkg::FUNC_W-1:0] req_func,
   input logic [PAGE_BITS-1:0]       req_page,
   input logic [FRAME_BITS-1:0]      req_frame_in,
   input logic                       rsp_valid,
   input logic                       rsp_ok,
   input logic [FRAME_BITS-1:0]      rsp_frame_out,
   input logic                       rsp_page_valid,
   input logic                       rsp_page_dirty
);

   logic accepted;
   logic no_fields;

   assign accepted  = start && !busy;
   assign no_fields = (rsp_frame_out == '0) && !rsp_page_valid && !rsp_page_dirty;

   // A transfer occupies the block and yields a result.
   `APT_ASSERT_NEXT(a_busy_after_accept, clock, reset, accepted, busy)
   `APT_ASSERT_IMPLY(a_result_latency, clock, reset, accepted, ##3 rsp_valid)
   // Results are strobes of one cycle, each while the block is occupied.
   `APT_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `APT_ASSERT_IMPLY(a_result_while_busy, clock, reset, rsp_valid, busy)
   // A failed or unmatched operation reports nothing else.
   `APT_ASSERT_IMPLY(a_miss_is_clean, clock, reset, rsp_valid && !rsp_ok, no_fields)

   logic unused_req;
   assign unused_req = ^{req_func, req_page, req_frame_in};

endmodule

bind associative_page_table apt_checker #(
   .PAGE_BITS  (PAGE_BITS),
   .FRAME_BITS (FRAME_BITS)
) u_apt_checker (.*);
